### rtl/lcrt_pkg.sv
// ----------------------------------------------------------------------------
// lcrt_pkg
// Shared types and constants for the lowest-cost retention table unit.
// ----------------------------------------------------------------------------
package lcrt_pkg;

   // Fixed field widths of the request and response transfers
   localparam int unsigned COST_W       = 32;
   localparam int unsigned TAG_FIELD_W  = 16;
   localparam int unsigned SLOT_FIELD_W = 6;
   localparam int unsigned CNT_FIELD_W  = 7;
   localparam int unsigned REQ_DATA_W   = COST_W + TAG_FIELD_W;
   localparam int unsigned RSP_DATA_W   = 1 + SLOT_FIELD_W + 1 + TAG_FIELD_W + 1 +
                                          TAG_FIELD_W + CNT_FIELD_W;

   // Request kinds carried on tuser
   localparam logic REQ_OFFER = 1'b0;
   localparam logic REQ_CLEAR = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } lcrt_state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;    // latch the accepted request
      logic scan_read;  // read the next entry of the scan
      logic commit;     // apply the request and load the response
   } lcrt_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_req;  // latched request is a clear
      logic full;       // every slot holds an entry
      logic scan_last;  // scan pointer sits on the last slot
      logic out_free;   // response register can take a new result
   } lcrt_stat_type;

endpackage

### rtl/lcrt_ram.sv
// ----------------------------------------------------------------------------
// lcrt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lcrt_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 32,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/lcrt_ctrl.sv
// ----------------------------------------------------------------------------
// lcrt_ctrl
// Sequencer: takes a request, runs the replacement scan when an offer finds
// the table full, then commits the result into the response register.
// ----------------------------------------------------------------------------
module lcrt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  lcrt_pkg::lcrt_stat_type stat,
   output lcrt_pkg::lcrt_cmd_type  cmd
);

   lcrt_pkg::lcrt_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcrt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_tready    = 1'b0;
      cmd.capture   = 1'b0;
      cmd.scan_read = 1'b0;
      cmd.commit    = 1'b0;
      case (state_ff)
         lcrt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = lcrt_pkg::ST_EXEC;
            end
         end
         lcrt_pkg::ST_EXEC: begin
            if (stat.clear_req || !stat.full) begin
               state_in = lcrt_pkg::ST_COMMIT;
            end else begin
               state_in = lcrt_pkg::ST_SCAN;
            end
         end
         lcrt_pkg::ST_SCAN: begin
            cmd.scan_read = 1'b1;
            if (stat.scan_last) begin
               state_in = lcrt_pkg::ST_DRAIN;
            end
         end
         lcrt_pkg::ST_DRAIN: begin
            // last read data is compared in this cycle
            state_in = lcrt_pkg::ST_COMMIT;
         end
         lcrt_pkg::ST_COMMIT: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = lcrt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lcrt_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/lcrt_dp.sv
// ----------------------------------------------------------------------------
// lcrt_dp
// Datapath: entry RAM, count and best-entry registers, worst-entry scan
// tracker and the response register.
// ----------------------------------------------------------------------------
module lcrt_dp #(
   parameter int unsigned CAPACITY = 32,
   parameter int unsigned TAG_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_type,
   input  logic [lcrt_pkg::COST_W-1:0]         req_cost,
   input  logic [lcrt_pkg::TAG_FIELD_W-1:0]    req_tag,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [lcrt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  lcrt_pkg::lcrt_cmd_type               cmd,
   output lcrt_pkg::lcrt_stat_type              stat
);

   localparam int unsigned AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned TW    = (TAG_BITS < lcrt_pkg::TAG_FIELD_W) ?
                                   TAG_BITS : lcrt_pkg::TAG_FIELD_W;
   localparam int unsigned WORD_W = lcrt_pkg::COST_W + TW;

   // latched request
   logic                        req_type_ff;
   logic [lcrt_pkg::COST_W-1:0] cost_ff;
   logic [TW-1:0]               tag_ff;

   // table state
   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        best_present_ff, best_present_in;
   logic [AW-1:0]               best_idx_ff, best_idx_in;
   logic [lcrt_pkg::COST_W-1:0] best_cost_ff, best_cost_in;
   logic [TW-1:0]               best_tag_ff, best_tag_in;

   // scan
   logic [AW-1:0]               scan_ff;
   logic                        cmp_vld_ff;
   logic [AW-1:0]               cmp_idx_ff;
   logic [lcrt_pkg::COST_W-1:0] max_cost_ff;
   logic [AW-1:0]               max_slot_ff;
   logic [TW-1:0]               max_tag_ff;

   // response
   logic                          rsp_valid_ff;
   logic [lcrt_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // RAM
   logic                        wr_en;
   logic [AW-1:0]               wr_slot;
   logic [WORD_W-1:0]           rd_word;
   logic [lcrt_pkg::COST_W-1:0] rd_cost;
   logic [TW-1:0]               rd_tag;

   logic                        full;
   logic                        out_free;

   lcrt_ram #(
      .WIDTH (WORD_W),
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_slot),
      .wr_data ({tag_ff, cost_ff}),
      .rd_en   (cmd.scan_read),
      .rd_addr (scan_ff),
      .rd_data (rd_word)
   );

   assign rd_cost  = rd_word[lcrt_pkg::COST_W-1:0];
   assign rd_tag   = rd_word[WORD_W-1:lcrt_pkg::COST_W];
   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign stat.clear_req = (req_type_ff == lcrt_pkg::REQ_CLEAR);
   assign stat.full      = full;
   assign stat.scan_last = (scan_ff == AW'(CAPACITY - 1));
   assign stat.out_free  = out_free;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_type_ff <= req_type;
         cost_ff     <= req_cost;
         tag_ff      <= req_tag[TW-1:0];
      end
   end

   // scan pointer and running worst entry; the first slot seeds the maximum,
   // later slots replace it only when strictly larger
   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff <= 1'b0;
         scan_ff    <= '0;
      end else begin
         cmp_vld_ff <= cmd.scan_read;
         if (cmd.capture) begin
            scan_ff <= '0;
         end else if (cmd.scan_read && !stat.scan_last) begin
            scan_ff <= scan_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= scan_ff;
      if (cmp_vld_ff && (cmp_idx_ff == '0 || rd_cost > max_cost_ff)) begin
         max_cost_ff <= rd_cost;
         max_slot_ff <= cmp_idx_ff;
         max_tag_ff  <= rd_tag;
      end
   end

   always_comb begin
      logic                              store;
      logic                              evict;
      logic                              keep_best;
      logic [lcrt_pkg::TAG_FIELD_W-1:0]  ev_tag_ext;
      logic [lcrt_pkg::TAG_FIELD_W-1:0]  best_tag_ext;
      logic [lcrt_pkg::SLOT_FIELD_W-1:0] slot_ext;
      logic [lcrt_pkg::CNT_FIELD_W-1:0]  count_ext;

      count_in        = count_ff;
      best_present_in = best_present_ff;
      best_idx_in     = best_idx_ff;
      best_cost_in    = best_cost_ff;
      best_tag_in     = best_tag_ff;
      wr_en           = 1'b0;
      store           = 1'b0;
      evict           = 1'b0;
      keep_best       = best_present_ff;
      wr_slot         = full ? max_slot_ff : count_ff[AW-1:0];

      if (cmd.commit) begin
         if (req_type_ff == lcrt_pkg::REQ_CLEAR) begin
            count_in        = '0;
            best_present_in = 1'b0;
            best_idx_in     = '0;
         end else begin
            store = 1'b1;
            if (full) begin
               if (cost_ff > max_cost_ff) begin
                  store = 1'b0;
               end else begin
                  evict = 1'b1;
                  // evicting the best hands best to the newcomer
                  if (best_present_ff && best_idx_ff == max_slot_ff) begin
                     keep_best = 1'b0;
                  end
               end
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
            if (store) begin
               wr_en = 1'b1;
               if (!keep_best || cost_ff < best_cost_ff) begin
                  best_present_in = 1'b1;
                  best_idx_in     = wr_slot;
                  best_cost_in    = cost_ff;
                  best_tag_in     = tag_ff;
               end
            end
         end
      end

      ev_tag_ext   = '0;
      best_tag_ext = '0;
      slot_ext     = '0;
      count_ext    = '0;
      if (evict) begin
         ev_tag_ext[TW-1:0] = max_tag_ff;
      end
      if (best_present_in) begin
         best_tag_ext[TW-1:0] = best_tag_in;
      end
      if (store) begin
         slot_ext[AW-1:0] = wr_slot;
      end
      count_ext[CNT_W-1:0] = count_in;

      rsp_data_in = {count_ext, best_tag_ext, best_present_in, ev_tag_ext, evict,
                     slot_ext, store};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff        <= '0;
         best_present_ff <= 1'b0;
         best_idx_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         count_ff        <= count_in;
         best_present_ff <= best_present_in;
         best_idx_ff     <= best_idx_in;
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      best_cost_ff <= best_cost_in;
      best_tag_ff  <= best_tag_in;
      if (cmd.commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> out_free)
      else $error("commit overwrote a pending response");

   a_best_needs_entry: assert property (@(posedge clock) disable iff (reset)
      best_present_ff |-> count_ff != '0)
      else $error("best entry marked in an empty table");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit did not raise the response");

endmodule

### rtl/lowest_cost_retention_table_unit.sv
// ----------------------------------------------------------------------------
// lowest_cost_retention_table_unit
// Keeps the CAPACITY lowest-cost candidates and reports every change.
// ----------------------------------------------------------------------------
// Each request yields exactly one response. A clear, or an offer while the
// table has free slots, goes from EXEC straight to COMMIT. An offer to a full
// table also runs the worst-entry scan: the entry RAM has a single read port,
// so the scan reads one slot per cycle, then DRAIN and COMMIT follow. The
// response register lets the next request enter while a result still waits.
// Tags keep their low TAG_BITS bits (at most 16).
module lowest_cost_retention_table_unit #(
   parameter int unsigned CAPACITY = 32,
   parameter int unsigned TAG_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] cost, [47:32] solution_tag
   input  logic [lcrt_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] req_type
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] accepted, [6:1] slot, [7] evicted_valid, [23:8] evicted_tag,
   // [24] best_valid, [40:25] best_tag, [47:41] stored_count
   output logic [lcrt_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   lcrt_pkg::lcrt_cmd_type  cmd;
   lcrt_pkg::lcrt_stat_type stat;

   lcrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   lcrt_dp #(
      .CAPACITY (CAPACITY),
      .TAG_BITS (TAG_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_type   (req_tuser),
      .req_cost   (req_tdata[lcrt_pkg::COST_W-1:0]),
      .req_tag    (req_tdata[lcrt_pkg::REQ_DATA_W-1:lcrt_pkg::COST_W]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule
